>>> sv/modal_resonator_bank_assert.svh
// ----------------------------------------------------------------------------
// modal resonator bank assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef MODAL_RESONATOR_BANK_ASSERT_SVH
`define MODAL_RESONATOR_BANK_ASSERT_SVH

// property checked outside reset
`define MRB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mrb_pkg.sv
// ----------------------------------------------------------------------------
// mrb_pkg
// sizes, codes, transaction types and saturation helpers of the resonator bank
// ----------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

  localparam int MAX_MODES = 64;
  localparam int MAX_PICKS = 4;
  localparam int FRAC_BITS = 24;
  localparam int NCOEF     = 6;

  localparam int MODE_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int CNT_W  = $clog2(MAX_MODES + 1);
  localparam int WADR_W = (MAX_MODES * MAX_PICKS > 1) ? $clog2(MAX_MODES * MAX_PICKS) : 1;
  localparam int SUM_W  = 48 + CNT_W + 1;
  localparam int ACC_W  = (SUM_W > 56) ? SUM_W : 56;

  typedef enum logic [2:0] {
    SEL_A11, SEL_A12, SEL_A21, SEL_A22, SEL_B1, SEL_B2, SEL_ENABLE, SEL_PICK
  } coef_sel_e;

  typedef enum logic {
    CFG_ACTIVE_MODES, CFG_INPUT_GAIN
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_OP, ST_WAIT, ST_SHIFT, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_A11_D, OP_A12_V, OP_B1_P, OP_A21_D, OP_A22_V, OP_B2_P,
    OP_GAIN_W, OP_FORCE, OP_B1_PN, OP_B2_PN, OP_W_D, OP_W_V
  } op_e;

  typedef enum logic [2:0] {
    MUL_IDLE, MUL_PP0, MUL_PP1, MUL_PP2, MUL_PP3, MUL_RND, MUL_FIN
  } mul_ph_e;

  typedef struct packed {
    logic               req_type;
    logic [5:0]         mode_index;
    logic [2:0]         coef_sel;
    logic [1:0]         pick_index;
    logic signed [47:0] coef_value;
    logic signed [47:0] force_req;
  } in_item_t;

  typedef struct packed {
    logic signed [55:0] total_displ;
    logic signed [55:0] total_velo;
    logic signed [55:0] pick_displ;
    logic signed [55:0] pick_velo;
  } out_item_t;

  typedef struct packed {
    logic signed [47:0] displ;
    logic signed [47:0] velo;
    logic signed [47:0] force_p;
    logic               en;
  } mode_state_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic en_we;
    logic en_val;
  } cell_ctl_t;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
    logic signed [47:0] r;
    if ((&x[49:47]) || (~|x[49:47])) begin
      r = x[47:0];
    end else if (x[49]) begin
      r = {1'b1, 47'b0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [55:0] sat_out(input logic signed [ACC_W-1:0] x);
    logic signed [55:0] r;
    if ((&x[ACC_W-1:55]) || (~|x[ACC_W-1:55])) begin
      r = x[55:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, 55'b0};
    end else begin
      r = {1'b0, {55{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/mrb_qmul.sv
// ----------------------------------------------------------------------------
// mrb_qmul
// iterative fixed point multiply: four 24x24 partial products, rounding to
// nearest with ties away from zero, saturation to 48 bits
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_qmul import mrb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [47:0] a_i,
  input  wire logic signed [47:0] b_i,
  output logic                    done_o,
  output logic signed [47:0]      res_o
);

  mul_ph_e            ph_q, ph_d;
  logic [47:0]        ma_q, mb_q;
  logic               neg_q;
  logic [95:0]        acc_q;
  logic signed [47:0] res_q, res_d;
  logic               done_q;

  logic [23:0] ah, bh;
  logic [47:0] pp;
  logic [6:0]  sh;
  logic [95:0] pp_sh;
  logic [95:0] q;
  logic [47:0] lim, mag_r;

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      MUL_IDLE: if (start_i) ph_d = MUL_PP0;
      MUL_PP0:  ph_d = MUL_PP1;
      MUL_PP1:  ph_d = MUL_PP2;
      MUL_PP2:  ph_d = MUL_PP3;
      MUL_PP3:  ph_d = MUL_RND;
      MUL_RND:  ph_d = MUL_FIN;
      MUL_FIN:  ph_d = MUL_IDLE;
      default:  ph_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    ah = ma_q[23:0];
    bh = mb_q[23:0];
    sh = 7'd0;
    case (ph_q)
      MUL_PP1: begin
        bh = mb_q[47:24];
        sh = 7'd24;
      end
      MUL_PP2: begin
        ah = ma_q[47:24];
        sh = 7'd24;
      end
      MUL_PP3: begin
        ah = ma_q[47:24];
        bh = mb_q[47:24];
        sh = 7'd48;
      end
      default: ;
    endcase
    pp    = ah * bh;
    pp_sh = 96'(pp) << sh;
    q     = acc_q >> FRAC_BITS;
    lim   = neg_q ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    mag_r = (q > 96'(lim)) ? lim : q[47:0];
    res_d = neg_q ? -$signed(mag_r) : $signed(mag_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= MUL_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == MUL_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == MUL_IDLE && start_i) begin
      ma_q  <= a_i[47] ? 48'(-a_i) : 48'(a_i);
      mb_q  <= b_i[47] ? 48'(-b_i) : 48'(b_i);
      neg_q <= a_i[47] ^ b_i[47];
      acc_q <= '0;
    end else if (ph_q == MUL_PP0 || ph_q == MUL_PP1 || ph_q == MUL_PP2 ||
                 ph_q == MUL_PP3) begin
      acc_q <= acc_q + pp_sh;
    end else if (ph_q == MUL_RND) begin
      acc_q <= acc_q + (96'(1) << (FRAC_BITS - 1));
    end else if (ph_q == MUL_FIN) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> sv/mrb_cell.sv
// ----------------------------------------------------------------------------
// mrb_cell
// one ring cell: displacement, velocity, pending force and enable of a mode
// ----------------------------------------------------------------------------
`default_nettype none

module mrb_cell import mrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cell_ctl_t   ctl_i,
  input  wire mode_state_t shift_in_i,
  output mode_state_t      state_o
);

  mode_state_t state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (ctl_i.shift) begin
      state_d = shift_in_i;
    end else begin
      if (ctl_i.clear) begin
        state_d.displ   = '0;
        state_d.velo    = '0;
        state_d.force_p = '0;
      end
      if (ctl_i.en_we) begin
        state_d.en = ctl_i.en_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

>>> sv/modal_resonator_bank.sv
// ----------------------------------------------------------------------------
// modal_resonator_bank
// bank of bilinear second-order resonators with weighted pick points
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | in_item_t
//   out     | output    | out_valid / out_stall| out_item_t
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a table load is written when it is accepted; a sample walks the ring of mode
// cells once: each active enabled mode runs twelve multiplies on the one shared
// multiplier, and every other mode is only shifted past the head
// reset clears every mode cell and all control; tables hold garbage until loaded
// out_stall holds a result in the output register while the next transaction
// is already taken
// ----------------------------------------------------------------------------
`default_nettype none

module modal_resonator_bank import mrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [47:0] cfg_data_i
);

  state_e state_q, state_d;
  op_e    op_q;

  logic [6:0]         active_q;
  logic signed [47:0] gain_q;
  logic [1:0]         pick_q;
  logic signed [47:0] force_q;
  logic [CNT_W-1:0]   cnt_q;

  logic signed [49:0] acc1_q;
  logic signed [47:0] d1_q, v1_q, t_q, pn_q, dn_q, vn_q;
  logic signed [ACC_W-1:0] td_q, tv_q, pd_q, pv_q;
  out_item_t out_q;
  logic      out_valid_q;

  logic [47:0] coef_mem_q [NCOEF][MAX_MODES];
  logic [47:0] w_mem_q [MAX_MODES * MAX_PICKS];
  logic signed [47:0] coef_rd_q [NCOEF];
  logic signed [47:0] w_rd_q;

  mode_state_t ring_s [MAX_MODES];
  cell_ctl_t   ctl_s  [MAX_MODES];
  mode_state_t tail_in;

  logic in_acc, load, sample, mode_ok, pick_in_ok, pick_ok;
  logic cfg_act_wr, en_wr, last, head_active;
  logic shift_en, shift_comp, mul_start, mul_done;
  logic signed [47:0] mul_a, mul_b, mul_res, w_use;
  logic [WADR_W-1:0] w_wr_addr, w_rd_addr;
  logic [MODE_W-1:0] mode_addr;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign load        = in_acc && !in_data_i.req_type;
  assign sample      = in_acc && in_data_i.req_type;
  assign mode_ok     = 32'(in_data_i.mode_index) < MAX_MODES;
  assign pick_in_ok  = 32'(in_data_i.pick_index) < MAX_PICKS;
  assign pick_ok     = 32'(pick_q) < MAX_PICKS;
  assign mode_addr   = MODE_W'(in_data_i.mode_index);
  assign cfg_ready_o = 1'b1;
  assign cfg_act_wr  = cfg_valid_i && (cfg_index_i == CFG_ACTIVE_MODES) &&
                       (32'(cfg_data_i[6:0]) <= MAX_MODES);
  assign en_wr       = load && mode_ok && (in_data_i.coef_sel == SEL_ENABLE);
  assign last        = 32'(cnt_q) == MAX_MODES - 1;
  assign head_active = (32'(cnt_q) < 32'(active_q)) && ring_s[0].en;
  assign w_use       = pick_ok ? w_rd_q : '0;
  assign w_wr_addr   = WADR_W'(32'(in_data_i.mode_index) * MAX_PICKS +
                               32'(in_data_i.pick_index));
  assign w_rd_addr   = pick_ok ? WADR_W'(32'(cnt_q) * MAX_PICKS + 32'(pick_q))
                               : WADR_W'(32'(cnt_q) * MAX_PICKS);

  // mode ring, cell 0 is the head
  for (genvar i = 0; i < MAX_MODES; i++) begin : g_ring
    always_comb begin
      ctl_s[i].shift  = shift_en;
      ctl_s[i].clear  = (cfg_act_wr && (i >= 32'(cfg_data_i[6:0]))) ||
                        (en_wr && (32'(in_data_i.mode_index) == i) &&
                         !in_data_i.coef_value[0]);
      ctl_s[i].en_we  = en_wr && (32'(in_data_i.mode_index) == i);
      ctl_s[i].en_val = in_data_i.coef_value[0];
    end
    if (i == MAX_MODES - 1) begin : g_tail
      mrb_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl_s[i]), .shift_in_i(tail_in), .state_o(ring_s[i])
      );
    end else begin : g_mid
      mrb_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl_s[i]), .shift_in_i(ring_s[i+1]), .state_o(ring_s[i])
      );
    end
  end

  always_comb begin
    tail_in = ring_s[0];
    if (shift_comp) begin
      tail_in.displ   = dn_q;
      tail_in.velo    = vn_q;
      tail_in.force_p = pn_q;
      tail_in.en      = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NCOEF; k++) begin
      if (load && mode_ok && (32'(in_data_i.coef_sel) == k)) begin
        coef_mem_q[k][mode_addr] <= in_data_i.coef_value;
      end
      coef_rd_q[k] <= coef_mem_q[k][cnt_q[MODE_W-1:0]];
    end
    if (load && mode_ok && pick_in_ok && (in_data_i.coef_sel == SEL_PICK)) begin
      w_mem_q[w_wr_addr] <= in_data_i.coef_value;
    end
    w_rd_q <= w_mem_q[w_rd_addr];
  end

  always_comb begin
    state_d    = state_q;
    shift_en   = 1'b0;
    shift_comp = 1'b0;
    mul_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: if (sample) state_d = ST_SCAN;
      ST_SCAN: begin
        if (head_active) begin
          state_d = ST_OP;
        end else begin
          shift_en = 1'b1;
          state_d  = last ? ST_DONE : ST_SCAN;
        end
      end
      ST_OP: begin
        mul_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: if (mul_done) state_d = (op_q == OP_W_V) ? ST_SHIFT : ST_OP;
      ST_SHIFT: begin
        shift_en   = 1'b1;
        shift_comp = 1'b1;
        state_d    = last ? ST_DONE : ST_SCAN;
      end
      ST_DONE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = coef_rd_q[SEL_A11];
    mul_b = ring_s[0].displ;
    unique case (op_q)
      OP_A11_D:  begin mul_a = coef_rd_q[SEL_A11]; mul_b = ring_s[0].displ;   end
      OP_A12_V:  begin mul_a = coef_rd_q[SEL_A12]; mul_b = ring_s[0].velo;    end
      OP_B1_P:   begin mul_a = coef_rd_q[SEL_B1];  mul_b = ring_s[0].force_p; end
      OP_A21_D:  begin mul_a = coef_rd_q[SEL_A21]; mul_b = ring_s[0].displ;   end
      OP_A22_V:  begin mul_a = coef_rd_q[SEL_A22]; mul_b = ring_s[0].velo;    end
      OP_B2_P:   begin mul_a = coef_rd_q[SEL_B2];  mul_b = ring_s[0].force_p; end
      OP_GAIN_W: begin mul_a = gain_q;             mul_b = w_use;             end
      OP_FORCE:  begin mul_a = t_q;                mul_b = force_q;           end
      OP_B1_PN:  begin mul_a = coef_rd_q[SEL_B1];  mul_b = pn_q;              end
      OP_B2_PN:  begin mul_a = coef_rd_q[SEL_B2];  mul_b = pn_q;              end
      OP_W_D:    begin mul_a = w_use;              mul_b = dn_q;              end
      OP_W_V:    begin mul_a = w_use;              mul_b = vn_q;              end
      default: ;
    endcase
  end

  mrb_qmul u_qmul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .res_o(mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_A11_D;
      active_q    <= '0;
      gain_q      <= 48'sd1 <<< FRAC_BITS;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_act_wr) begin
        active_q <= cfg_data_i[6:0];
      end
      if (cfg_valid_i && (cfg_index_i == CFG_INPUT_GAIN)) begin
        gain_q <= cfg_data_i;
      end
      if (sample) begin
        cnt_q <= '0;
      end else if (shift_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_WAIT && mul_done) begin
        op_q <= (op_q == OP_W_V) ? OP_A11_D : op_e'(op_q + 4'd1);
      end
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample) begin
      pick_q  <= in_data_i.pick_index;
      force_q <= in_data_i.force_req;
      td_q    <= '0;
      tv_q    <= '0;
      pd_q    <= '0;
      pv_q    <= '0;
    end
    if (state_q == ST_WAIT && mul_done) begin
      unique case (op_q)
        OP_A11_D:  acc1_q <= 50'(mul_res);
        OP_A12_V:  acc1_q <= acc1_q + 50'(mul_res);
        OP_B1_P:   d1_q   <= sat48(acc1_q + 50'(mul_res));
        OP_A21_D:  acc1_q <= 50'(mul_res);
        OP_A22_V:  acc1_q <= acc1_q + 50'(mul_res);
        OP_B2_P:   v1_q   <= sat48(acc1_q + 50'(mul_res));
        OP_GAIN_W: t_q    <= mul_res;
        OP_FORCE:  pn_q   <= mul_res;
        OP_B1_PN:  dn_q   <= sat48(50'(d1_q) + 50'(mul_res));
        OP_B2_PN:  vn_q   <= sat48(50'(v1_q) + 50'(mul_res));
        OP_W_D: begin
          pd_q <= pd_q + ACC_W'(mul_res);
          td_q <= td_q + ACC_W'(dn_q);
          tv_q <= tv_q + ACC_W'(vn_q);
        end
        OP_W_V:    pv_q   <= pv_q + ACC_W'(mul_res);
        default: ;
      endcase
    end
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.total_displ <= sat_out(td_q);
      out_q.total_velo  <= sat_out(tv_q);
      out_q.pick_displ  <= sat_out(pd_q);
      out_q.pick_velo   <= sat_out(pv_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sv/mrb_checker.sv
// ----------------------------------------------------------------------------
// mrb_checker
// port level checks of the resonator bank, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "modal_resonator_bank_assert.svh"

module mrb_checker import mrb_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire in_item_t    in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire out_item_t   out_data_o
);

  `MRB_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `MRB_ASSERT(a_sample_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.req_type |=> in_stall_o, "sample transaction did not occupy the bank")
  `MRB_ASSERT(a_load_silent, clk_i, rst_ni, in_valid_i && !in_stall_o && !in_data_i.req_type && !out_valid_o |=> !out_valid_o, "load transaction produced a result")
  `MRB_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o, "bank not quiet in reset")

endmodule

bind modal_resonator_bank mrb_checker u_mrb_checker (.*);

`default_nettype wire

>>> tb/modal_resonator_bank_test.sv
// ----------------------------------------------------------------------------
// modal_resonator_bank_test
// self-checking bench for the resonator bank: a bit-exact predictor follows
// every accepted table load, sample and register write, and each result is
// compared with the oldest predicted one under random idling on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module modal_resonator_bank_test;
  import mrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
  localparam int   NMODES     = 64;
  localparam int   NPICKS     = 4;
  localparam int   STALL_LIMIT = 60000;
  localparam logic signed [47:0] Q_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] Q_MIN = {1'b1, 47'b0};
  localparam logic signed [47:0] Q_ONE = 48'sd16777216;
  localparam longint S48_MAX = 64'sh7FFFFFFFFFFF;
  localparam longint S48_MIN = -64'sh800000000000;
  localparam longint S56_MAX = 64'sh7FFFFFFFFFFFFF;
  localparam longint S56_MIN = -64'sh80000000000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_item_t in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic cfg_index = 1'b0;
  logic [47:0] cfg_data = '0;

  modal_resonator_bank u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // bank state as predicted
  logic signed [47:0] displ_q [NMODES];
  logic signed [47:0] velo_q  [NMODES];
  logic signed [47:0] force_q [NMODES];
  logic signed [47:0] coef_q  [NMODES][NCOEF];
  logic signed [47:0] weight_q[NMODES][NPICKS];
  logic               enabled_q[NMODES];
  int unsigned        active_q;
  logic signed [47:0] gain_q;

  out_item_t sums_expected[$];
  int  n_mismatch = 0;
  int  n_results  = 0;
  int  n_loads    = 0;
  int  n_samples  = 0;
  int  n_cfg      = 0;
  bit  quiet      = 1'b0;
  bit  start_hold = 1'b0;
  int  hold_cnt   = 0;
  int  idle_cycles = 0;

  function automatic logic signed [47:0] q_mul(logic signed [47:0] a, logic signed [47:0] b);
    logic        neg;
    logic [47:0] ma, mb, lim;
    logic [95:0] pr;
    neg = a[47] ^ b[47];
    ma  = a[47] ? (~a + 48'd1) : a;
    mb  = b[47] ? (~b + 48'd1) : b;
    pr  = {48'b0, ma} * {48'b0, mb};
    pr  = (pr + (96'd1 << 23)) >> FRAC_BITS;
    lim = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
    if (pr > {48'b0, lim}) pr = {48'b0, lim};
    return neg ? -pr[47:0] : pr[47:0];
  endfunction

  function automatic logic signed [47:0] clip48(longint x);
    return (x > S48_MAX) ? S48_MAX[47:0] : (x < S48_MIN) ? S48_MIN[47:0] : x[47:0];
  endfunction

  function automatic logic signed [55:0] clip56(longint x);
    return (x > S56_MAX) ? S56_MAX[55:0] : (x < S56_MIN) ? S56_MIN[55:0] : x[55:0];
  endfunction

  function automatic void clear_mode(int m);
    displ_q[m] = '0;
    velo_q[m]  = '0;
    force_q[m] = '0;
  endfunction

  function automatic void reset_bank();
    for (int m = 0; m < NMODES; m++) begin
      clear_mode(m);
      enabled_q[m] = 1'b0;
      for (int c = 0; c < NCOEF; c++) coef_q[m][c] = '0;
      for (int p = 0; p < NPICKS; p++) weight_q[m][p] = '0;
    end
    active_q = 0;
    gain_q   = Q_ONE;
  endfunction

  // advance the bank by one accepted transaction
  function automatic void bank_update(in_item_t it);
    longint td, tv, pd, pv;
    logic signed [47:0] d1, v1, p, w;
    out_item_t r;
    int m;
    td = 0; tv = 0; pd = 0; pv = 0;
    m = it.mode_index;
    if (it.req_type == REQ_LOAD) begin
      n_loads++;
      if (it.coef_sel < SEL_ENABLE) begin
        coef_q[m][it.coef_sel] = it.coef_value;
      end else if (it.coef_sel == SEL_ENABLE) begin
        if (enabled_q[m] && !it.coef_value[0]) clear_mode(m);
        enabled_q[m] = it.coef_value[0];
      end else begin
        weight_q[m][it.pick_index] = it.coef_value;
      end
      return;
    end
    n_samples++;
    for (m = 0; m < active_q && m < NMODES; m++) begin
      if (!enabled_q[m]) continue;
      w  = weight_q[m][it.pick_index];
      d1 = clip48(longint'(q_mul(coef_q[m][SEL_A11], displ_q[m]))
                + longint'(q_mul(coef_q[m][SEL_A12], velo_q[m]))
                + longint'(q_mul(coef_q[m][SEL_B1], force_q[m])));
      v1 = clip48(longint'(q_mul(coef_q[m][SEL_A21], displ_q[m]))
                + longint'(q_mul(coef_q[m][SEL_A22], velo_q[m]))
                + longint'(q_mul(coef_q[m][SEL_B2], force_q[m])));
      p  = q_mul(q_mul(gain_q, w), it.force_req);
      displ_q[m] = clip48(longint'(d1) + longint'(q_mul(coef_q[m][SEL_B1], p)));
      velo_q[m]  = clip48(longint'(v1) + longint'(q_mul(coef_q[m][SEL_B2], p)));
      force_q[m] = p;
      td += displ_q[m];
      tv += velo_q[m];
      pd += q_mul(w, displ_q[m]);
      pv += q_mul(w, velo_q[m]);
    end
    r.total_displ = clip56(td);
    r.total_velo  = clip56(tv);
    r.pick_displ  = clip56(pd);
    r.pick_velo   = clip56(pv);
    sums_expected.push_back(r);
  endfunction

  // receiver: random stall, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (start_hold) begin
      hold_cnt  <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 25);
    end
  end

  function automatic void check_field(string name, logic [55:0] exp_v, logic [55:0] act_v);
    if (exp_v !== act_v) begin
      n_mismatch++;
      $display("%0t: %s expected %0d actual %0d", $realtime, name,
               $signed(exp_v), $signed(act_v));
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (sums_expected.size() == 0) begin
        n_mismatch++;
        $display("%0t: unexpected result, expected none actual %h", $realtime, out_data_o);
      end else begin
        e = sums_expected.pop_front();
        n_results++;
        check_field("total_displ", e.total_displ, out_data_o.total_displ);
        check_field("total_velo", e.total_velo, out_data_o.total_velo);
        check_field("pick_displ", e.pick_displ, out_data_o.pick_displ);
        check_field("pick_velo", e.pick_velo, out_data_o.pick_velo);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout", $realtime);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [47:0] rand_q();
    logic signed [31:0] s;
    s = $urandom;
    case ($urandom_range(0, 9))
      0: return 48'({$urandom, $urandom});
      1: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          3: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      default: return 48'(s >>> 6);
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bank_update(it);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_load(int m, coef_sel_e sel, int pick, logic signed [47:0] val);
    in_item_t it;
    it = '0;
    it.req_type   = REQ_LOAD;
    it.mode_index = 6'(m);
    it.coef_sel   = sel;
    it.pick_index = 2'(pick);
    it.coef_value = val;
    it.force_req  = 48'({$urandom, $urandom});
    send_item(it);
  endtask

  task automatic send_sample(int pick, logic signed [47:0] f);
    in_item_t it;
    it.req_type   = REQ_SAMPLE;
    it.mode_index = 6'($urandom);
    it.coef_sel   = 3'($urandom);
    it.pick_index = 2'(pick);
    it.coef_value = 48'({$urandom, $urandom});
    it.force_req  = f;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sums_expected.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [47:0] val);
    drain();
    repeat (20) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx == CFG_ACTIVE_MODES) begin
      if (val[6:0] <= NMODES) begin
        for (int m = val[6:0]; m < NMODES; m++) clear_mode(m);
        active_q = val[6:0];
      end
    end else begin
      gain_q = val;
    end
  endtask

  task automatic set_active(int n);
    write_reg(CFG_ACTIVE_MODES, (48'({$urandom, $urandom}) & 48'hFFFFFFFFFF80) | 48'(n));
  endtask

  task automatic test_table_init();
    for (int m = 0; m < NMODES; m++) begin
      for (int c = 0; c < NCOEF; c++) send_load(m, coef_sel_e'(c), $urandom, rand_q());
      for (int p = 0; p < NPICKS; p++) send_load(m, SEL_PICK, p, rand_q());
      send_load(m, SEL_ENABLE, $urandom, 48'({$urandom, $urandom}) | 48'd1);
    end
  endtask

  task automatic test_directed();
    set_active(4);
    send_sample(0, Q_MAX);
    send_sample(3, Q_MIN);
    send_sample(1, '0);
    send_load(0, SEL_A11, 0, Q_MAX);
    send_load(1, SEL_A12, 0, Q_MIN);
    send_load(2, SEL_B1, 0, Q_MIN);
    send_load(3, SEL_B2, 0, Q_MAX);
    send_sample(2, Q_MAX);
    send_load(2, SEL_ENABLE, 0, 48'hFFFFFFFFFFFE);  // disable clears the mode
    send_sample(1, rand_q());
    send_load(2, SEL_ENABLE, 0, 48'd1);
    send_load(3, SEL_PICK, 3, Q_MIN);
    send_load(3, SEL_PICK, 2, Q_MAX);
    send_sample(3, Q_MIN);
    send_sample(2, Q_MAX);
    set_active(65);  // above the bank, ignored
    send_sample(0, Q_ONE);
    set_active(127);
    write_reg(CFG_INPUT_GAIN, Q_MAX);
    send_sample(0, Q_MAX);
    write_reg(CFG_INPUT_GAIN, Q_MIN);
    send_sample(3, Q_MAX);
    set_active(0);
    send_sample(1, Q_MAX);
    set_active(NMODES);
    send_sample(2, Q_MIN);
    write_reg(CFG_INPUT_GAIN, Q_ONE);
    drain();
  endtask

  task automatic test_backpressure();
    set_active(2);
    start_hold <= 1'b1;
    @(posedge clk_i);
    start_hold <= 1'b0;
    for (int i = 0; i < 20; i++) send_sample($urandom_range(0, 3), rand_q());
    drain();
  endtask

  task automatic test_random(int rounds, int items);
    int lim;
    for (int r = 0; r < rounds; r++) begin
      quiet = (r == 3);
      set_active($urandom_range(0, 8));
      write_reg(CFG_INPUT_GAIN, rand_q());
      lim = (active_q > 0) ? active_q + 1 : 2;
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(0, 99) < 45) begin
          send_sample($urandom_range(0, 3), rand_q());
        end else if ($urandom_range(0, 9) < 2) begin
          send_load($urandom_range(0, lim), SEL_ENABLE, $urandom,
                    48'({$urandom, $urandom}));
        end else begin
          send_load($urandom_range(0, lim), coef_sel_e'($urandom_range(0, 7)),
                    $urandom_range(0, 3), rand_q());
        end
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  task automatic test_full_bank();
    for (int m = 0; m < NMODES; m++) send_load(m, SEL_ENABLE, 0, 48'd1);
    set_active(NMODES);
    write_reg(CFG_INPUT_GAIN, rand_q());
    for (int i = 0; i < 3; i++) send_sample($urandom_range(0, 3), rand_q());
    set_active(0);
    send_sample(0, Q_MAX);
    drain();
  endtask

  initial begin
    reset_bank();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_init();
    test_directed();
    test_backpressure();
    test_random(10, 130);
    test_full_bank();
    drain();
    repeat (200) @(posedge clk_i);
    $display("covered %0d table loads, %0d samples, %0d register writes",
             n_loads, n_samples, n_cfg);
    $display("checked %0d results, including full bank and long output hold-off",
             n_results);
    if (n_mismatch == 0 && sums_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/mrb_pkg.sv
sv/mrb_qmul.sv
sv/mrb_cell.sv
sv/modal_resonator_bank.sv
sv/mrb_checker.sv
tb/modal_resonator_bank_test.sv
